[rtl/lpsc_pkg.sv]
// Shared types and constants for the length-prefix to start-code converter.
package lpsc_pkg;

    localparam int unsigned SIZE_BYTES_W     = 4;
    localparam int unsigned REM_W            = 64;
    localparam int unsigned QUEUE_DEPTH      = 2;
    localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W           = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned START_CODE_LEN   = 3;
    localparam int unsigned SC_CNT_W         = $clog2(START_CODE_LEN);

    localparam logic [SIZE_BYTES_W-1:0] SIZE_BYTES_MAX   = 4'd8;
    localparam logic [SIZE_BYTES_W-1:0] SIZE_BYTES_MIN   = 4'd1;
    localparam logic [SIZE_BYTES_W-1:0] SIZE_BYTES_RESET = 4'd4;
    localparam logic [SC_CNT_W-1:0]     SC_LAST_IDX      = SC_CNT_W'(START_CODE_LEN - 1);
    localparam logic [7:0]              START_BYTE_ZERO  = 8'h00;
    localparam logic [7:0]              START_BYTE_ONE   = 8'h01;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

    // One classified job for the back end.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       done;
        logic       err;
    } cmd_t;

endpackage

[rtl/lpsc_if.sv]
// Valid/ready channel interfaces for the input bytes and the result items.
interface lpsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface lpsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       done_res;
    logic       error;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output done_res, output error, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input run_last,
                    input done_res, input error, output ready);
endinterface

[rtl/length_prefix_to_start_code_unit.sv]
// An item's first result passes through a queue entry and then the output register, and the
// sink takes it from the output register, where back-pressure on sc.ready holds it.
// Throughput: one input byte per cycle while the queue is not full; a completed size field
// expands into a three-byte start code, sent one byte per result through the single output
// register of the back end. Middle size bytes produce no result.
// Reset (rst_n low, asynchronous) empties queue and output, clears unit state,
// and sets the size field width to 4 bytes.
module length_prefix_to_start_code_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lpsc_pkg::SIZE_BYTES_W-1:0] cfg_wr_data,
    lpsc_in_if.sink                           lp,
    lpsc_out_if.source                        sc
);

    logic           fr_push;
    lpsc_pkg::cmd_t fr_cmd;
    logic           q_full;
    logic           q_pop;
    logic           q_head_valid;
    lpsc_pkg::cmd_t q_head_cmd;

    lpsc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .lp          (lp),
        .q_full      (q_full),
        .push        (fr_push),
        .push_cmd    (fr_cmd)
    );

    lpsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fr_push),
        .push_cmd   (fr_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    lpsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .sc         (sc)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fr_push && q_full))
        else $error("command pushed into a full queue");

    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("command popped from an empty queue");

    a_error_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        sc.valid && sc.error |-> sc.done_res && sc.run_last)
        else $error("error flagged on a result that does not end the buffer");

    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        sc.valid && !sc.has_byte |-> sc.done_res && sc.run_last && !sc.error)
        else $error("status-only result that is not a clean buffer end");

endmodule

[rtl/lpsc_front.sv]
// Front end: accepts input bytes, tracks the size field and payload count, classifies.
module lpsc_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [lpsc_pkg::SIZE_BYTES_W-1:0]    cfg_wr_data,
    lpsc_in_if.sink                              lp,
    input  logic                                 q_full,
    output logic                                 push,
    output lpsc_pkg::cmd_t                       push_cmd
);

    logic [lpsc_pkg::SIZE_BYTES_W-1:0] size_bytes_reg;
    logic                              phase_reg, phase_next;
    logic [lpsc_pkg::SIZE_BYTES_W-1:0] idx_reg, idx_next;
    logic [lpsc_pkg::REM_W-1:0]        rem_reg, rem_next;

    logic [lpsc_pkg::SIZE_BYTES_W-1:0] eff_width;
    logic [lpsc_pkg::REM_W-1:0]        rem_dec;
    logic [lpsc_pkg::REM_W-1:0]        rem_shift;
    logic [lpsc_pkg::SIZE_BYTES_W-1:0] idx_inc;
    logic                              accept;

    assign lp.ready = !q_full;
    assign accept   = lp.valid && lp.ready;

    always_comb
    begin
        priority if (size_bytes_reg == '0)
            eff_width = lpsc_pkg::SIZE_BYTES_MIN;
        else if (size_bytes_reg > lpsc_pkg::SIZE_BYTES_MAX)
            eff_width = lpsc_pkg::SIZE_BYTES_MAX;
        else
            eff_width = size_bytes_reg;
    end

    assign rem_dec   = rem_reg - lpsc_pkg::REM_W'(1);
    assign rem_shift = {rem_reg[lpsc_pkg::REM_W-9:0], lp.in_byte};
    assign idx_inc   = idx_reg + lpsc_pkg::SIZE_BYTES_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        rem_next      = rem_reg;
        push          = 1'b0;
        push_cmd.kind = lpsc_pkg::CMD_DATA;
        push_cmd.data = lp.in_byte;
        push_cmd.done = lp.is_last;
        push_cmd.err  = 1'b0;
        if (accept)
        begin
            if (phase_reg)
            begin
                push         = 1'b1;
                push_cmd.err = (rem_dec != '0);
                if (rem_dec == '0 || lp.is_last)
                begin
                    phase_next = 1'b0;
                    idx_next   = '0;
                    rem_next   = '0;
                end
                else
                begin
                    rem_next = rem_dec;
                end
            end
            else if (idx_inc >= eff_width)
            begin
                push          = 1'b1;
                push_cmd.kind = lpsc_pkg::CMD_START;
                push_cmd.err  = (rem_shift != '0);
                idx_next      = '0;
                if (lp.is_last || rem_shift == '0)
                begin
                    phase_next = 1'b0;
                    rem_next   = '0;
                end
                else
                begin
                    phase_next = 1'b1;
                    rem_next   = rem_shift;
                end
            end
            else if (lp.is_last)
            begin
                // drop the partial size field
                push          = 1'b1;
                push_cmd.kind = lpsc_pkg::CMD_STATUS;
                idx_next      = '0;
                rem_next      = '0;
            end
            else
            begin
                idx_next = idx_inc;
                rem_next = rem_shift;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_bytes_reg <= lpsc_pkg::SIZE_BYTES_RESET;
            phase_reg      <= 1'b0;
            idx_reg        <= '0;
            rem_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                size_bytes_reg <= cfg_wr_data;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

[rtl/lpsc_queue.sv]
// Short command queue between the front and back ends.
module lpsc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lpsc_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lpsc_pkg::cmd_t head_cmd
);

    lpsc_pkg::cmd_t                  entry_reg [lpsc_pkg::QUEUE_DEPTH];
    logic [lpsc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lpsc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lpsc_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full       = (count_reg == lpsc_pkg::QCNT_W'(lpsc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == lpsc_pkg::QPTR_W'(lpsc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + lpsc_pkg::QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == lpsc_pkg::QPTR_W'(lpsc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + lpsc_pkg::QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + lpsc_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - lpsc_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/lpsc_back.sv]
// Back end: expands commands into result items and holds them in an output register.
module lpsc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  lpsc_pkg::cmd_t head_cmd,
    output logic           pop,
    lpsc_out_if.source     sc
);

    logic                          valid_reg;
    logic [7:0]                    byte_reg, byte_next;
    logic                          has_reg, has_next;
    logic                          run_last_reg, run_last_next;
    logic                          done_reg, done_next;
    logic                          err_reg, err_next;
    logic [lpsc_pkg::SC_CNT_W-1:0] sc_cnt_reg, sc_cnt_next;
    logic                          load;

    assign load = head_valid && (!valid_reg || sc.ready);

    always_comb
    begin
        pop           = 1'b0;
        sc_cnt_next   = sc_cnt_reg;
        byte_next     = head_cmd.data;
        has_next      = 1'b1;
        run_last_next = 1'b1;
        done_next     = head_cmd.done;
        err_next      = head_cmd.done && head_cmd.err;
        unique case (head_cmd.kind)
            lpsc_pkg::CMD_START:
            begin
                if (sc_cnt_reg == lpsc_pkg::SC_LAST_IDX)
                begin
                    byte_next = lpsc_pkg::START_BYTE_ONE;
                    pop       = load;
                    if (load)
                        sc_cnt_next = '0;
                end
                else
                begin
                    byte_next     = lpsc_pkg::START_BYTE_ZERO;
                    run_last_next = 1'b0;
                    done_next     = 1'b0;
                    err_next      = 1'b0;
                    if (load)
                        sc_cnt_next = sc_cnt_reg + lpsc_pkg::SC_CNT_W'(1);
                end
            end
            lpsc_pkg::CMD_DATA:
            begin
                pop = load;
            end
            lpsc_pkg::CMD_STATUS:
            begin
                byte_next = '0;
                has_next  = 1'b0;
                done_next = 1'b1;
                err_next  = 1'b0;
                pop       = load;
            end
            default:
            begin
                pop = load;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= byte_next;
            has_reg      <= has_next;
            run_last_reg <= run_last_next;
            done_reg     <= done_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            sc_cnt_reg <= '0;
        end
        else
        begin
            sc_cnt_reg <= sc_cnt_next;
            if (load)
                valid_reg <= 1'b1;
            else if (sc.ready)
                valid_reg <= 1'b0;
        end
    end

    assign sc.valid    = valid_reg;
    assign sc.out_byte = byte_reg;
    assign sc.has_byte = has_reg;
    assign sc.run_last = run_last_reg;
    assign sc.done_res = done_reg;
    assign sc.error    = err_reg;

endmodule
